>>> src/tem_pkg.sv
// Shared types and constants for the P1 triangle element matrix pipeline.
// Used by p1_triangle_element_matrices; depends on nothing.
package tem_pkg;

   localparam int CoordW   = 32;
   localparam int DiffW    = CoordW + 1;
   localparam int ProdW    = 2 * DiffW;
   localparam int SumW     = ProdW + 1;
   localparam int QuoW     = 33;
   localparam int StiffDivW = 101;
   localparam int NumStiff = 6;
   localparam int DivLat   = QuoW + 1;

   // Mass path: floor(|det| / (12 * 2^16)) = floor((|det| >> 18) / 3)
   localparam int MassNW  = 35;
   localparam int MassQW  = 33;
   localparam int MassLat = DivLat - 1;
   // ceil(2^36 / 3) split at bit 18
   localparam logic [16:0] MassRecipHi = 17'h15555;
   localparam logic [17:0] MassRecipLo = 18'h15556;

   typedef logic signed [CoordW-1:0] coord_type;
   typedef logic signed [DiffW-1:0]  diff_type;
   typedef logic signed [ProdW-1:0]  prod_type;
   typedef logic signed [SumW-1:0]   wsum_type;

   // Control that rides alongside the divider lanes
   typedef struct packed {
      logic                valid;
      logic                degen;
      logic [NumStiff-1:0] neg;
   } side_type;

   // Unclipped |det| / (12 * 2^16) and a flag for values of 2^33 and above
   typedef struct packed {
      logic              big;
      logic [MassQW-1:0] quo;
   } mass_type;

endpackage

>>> src/p1_triangle_element_matrices.sv
// P1 triangle element matrices: takes one triangle (three Q15.16 vertices) per
// transaction and returns the six distinct Laplace stiffness entries and the two
// consistent mass entries. A new triangle is taken every cycle while the response
// side does not stall; a result passes through five arithmetic stages, the
// 34-stage bit-per-stage quotient pipelines (six stiffness lanes) and the output
// register. The mass entries come from a two-stage reciprocal multiply by 1/3 and
// are delayed to line up with the stiffness lanes.
// A stall on the response side holds the whole pipeline. Depends on tem_pkg and
// tem_divpipe.
module p1_triangle_element_matrices (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y
   input  logic [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // stiff_00, stiff_01, stiff_02, stiff_11, stiff_12, stiff_22,
   // mass_diagonal, mass_offdiagonal
   output logic [255:0] rsp_tdata,
   // degenerate, saturated
   output logic [1:0]   rsp_tuser
);

   localparam int NS = tem_pkg::NumStiff;
   localparam int QW = tem_pkg::QuoW;
   localparam int SW = tem_pkg::SumW;
   localparam int LI [NS] = '{0, 0, 0, 1, 1, 2};
   localparam int LJ [NS] = '{0, 1, 2, 1, 2, 2};

   logic en;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   tem_pkg::coord_type x_ff [3];
   tem_pkg::coord_type y_ff [3];
   tem_pkg::diff_type  ex_ff [3];
   tem_pkg::diff_type  ey_ff [3];
   tem_pkg::prod_type  pdet_a_ff, pdet_b_ff;
   tem_pkg::prod_type  px_ff [NS];
   tem_pkg::prod_type  py_ff [NS];
   tem_pkg::wsum_type  det_ff;
   tem_pkg::wsum_type  dot_ff [NS];

   logic [SW-1:0] absdet_ff;
   logic [SW-1:0] mag_ff [NS];
   tem_pkg::side_type side_ff [tem_pkg::DivLat+1];

   logic [QW-1:0] squo [NS];
   logic          sovf [NS];

   logic [tem_pkg::MassNW-1:0] mass_n;
   logic                       mass_big;
   logic [35:0]                mp_ff [4];
   logic                       mbig_ff;
   logic [71:0]                mass_sum;
   tem_pkg::mass_type          md_ff [tem_pkg::MassLat];

   logic         rsp_tvalid_ff;
   logic [255:0] rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]   rsp_tuser_ff, rsp_tuser_in;

   assign en = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Stage 1: capture vertices; stage 2: edge vectors
   always_ff @(posedge clock) begin
      if (en) begin
         for (int v = 0; v < 3; v++) begin
            x_ff[v] <= req_tdata[64*v +: 32];
            y_ff[v] <= req_tdata[64*v+32 +: 32];
         end
         ex_ff[0] <= tem_pkg::diff_type'(x_ff[2]) - tem_pkg::diff_type'(x_ff[1]);
         ey_ff[0] <= tem_pkg::diff_type'(y_ff[2]) - tem_pkg::diff_type'(y_ff[1]);
         ex_ff[1] <= tem_pkg::diff_type'(x_ff[0]) - tem_pkg::diff_type'(x_ff[2]);
         ey_ff[1] <= tem_pkg::diff_type'(y_ff[0]) - tem_pkg::diff_type'(y_ff[2]);
         ex_ff[2] <= tem_pkg::diff_type'(x_ff[1]) - tem_pkg::diff_type'(x_ff[0]);
         ey_ff[2] <= tem_pkg::diff_type'(y_ff[1]) - tem_pkg::diff_type'(y_ff[0]);
      end
   end

   // Stage 3: products; det = e1x*e2y - e2x*e1y
   always_ff @(posedge clock) begin
      if (en) begin
         pdet_a_ff <= tem_pkg::prod_type'(ex_ff[1]) * tem_pkg::prod_type'(ey_ff[2]);
         pdet_b_ff <= tem_pkg::prod_type'(ex_ff[2]) * tem_pkg::prod_type'(ey_ff[1]);
         for (int l = 0; l < NS; l++) begin
            px_ff[l] <= tem_pkg::prod_type'(ex_ff[LI[l]]) * tem_pkg::prod_type'(ex_ff[LJ[l]]);
            py_ff[l] <= tem_pkg::prod_type'(ey_ff[LI[l]]) * tem_pkg::prod_type'(ey_ff[LJ[l]]);
         end
      end
   end

   // Stage 4: sums
   always_ff @(posedge clock) begin
      if (en) begin
         det_ff <= tem_pkg::wsum_type'(pdet_a_ff) - tem_pkg::wsum_type'(pdet_b_ff);
         for (int l = 0; l < NS; l++) begin
            dot_ff[l] <= tem_pkg::wsum_type'(px_ff[l]) + tem_pkg::wsum_type'(py_ff[l]);
         end
      end
   end

   // Stage 5: magnitudes and signs
   always_ff @(posedge clock) begin
      if (en) begin
         absdet_ff <= det_ff[SW-1] ? SW'(-det_ff) : SW'(det_ff);
         for (int l = 0; l < NS; l++) begin
            mag_ff[l] <= dot_ff[l][SW-1] ? SW'(-dot_ff[l]) : SW'(dot_ff[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= tem_pkg::DivLat; s++) begin
            side_ff[s].valid <= 1'b0;
         end
      end else if (en) begin
         side_ff[0].valid <= v4_ff;
         side_ff[0].degen <= det_ff == '0;
         for (int l = 0; l < NS; l++) begin
            side_ff[0].neg[l] <= dot_ff[l][SW-1];
         end
         for (int s = 0; s < tem_pkg::DivLat; s++) begin
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   // Stiffness: |dot| * 2^16 / (2|det|)
   for (genvar l = 0; l < NS; l++) begin : g_stiff
      tem_divpipe #(.W(tem_pkg::StiffDivW), .Q(QW)) u_div (
         .clock (clock),
         .en    (en),
         .num   (tem_pkg::StiffDivW'({mag_ff[l], 16'h0000})),
         .den   (tem_pkg::StiffDivW'({absdet_ff, 1'b0})),
         .quo   (squo[l]),
         .ovf   (sovf[l])
      );
   end

   // Mass: (|det| >> 18) / 3 by reciprocal multiply, split into four partial
   // products; the off-diagonal entry is half of the unclipped diagonal quotient
   assign mass_n   = absdet_ff[18 +: tem_pkg::MassNW];
   assign mass_big = absdet_ff[SW-1:18] >= (SW-18)'(35'h6_0000_0000);

   always_ff @(posedge clock) begin
      if (en) begin
         mbig_ff  <= mass_big;
         mp_ff[0] <= 36'(mass_n[34:18]) * 36'(tem_pkg::MassRecipHi);
         mp_ff[1] <= 36'(mass_n[34:18]) * 36'(tem_pkg::MassRecipLo);
         mp_ff[2] <= 36'(mass_n[17:0]) * 36'(tem_pkg::MassRecipHi);
         mp_ff[3] <= 36'(mass_n[17:0]) * 36'(tem_pkg::MassRecipLo);
      end
   end

   assign mass_sum = {mp_ff[0], 36'h0} + {18'h0, mp_ff[1] + mp_ff[2], 18'h0}
                     + {36'h0, mp_ff[3]};

   always_ff @(posedge clock) begin
      if (en) begin
         md_ff[0].big <= mbig_ff;
         md_ff[0].quo <= mass_sum[36 +: tem_pkg::MassQW];
         for (int s = 1; s < tem_pkg::MassLat; s++) begin
            md_ff[s] <= md_ff[s-1];
         end
      end
   end

   // Clip, apply sign, force zeros on a degenerate triangle
   always_comb begin
      logic sat;
      tem_pkg::side_type sd;
      tem_pkg::mass_type md;
      sd  = side_ff[tem_pkg::DivLat];
      md  = md_ff[tem_pkg::MassLat-1];
      sat = 1'b0;
      rsp_tdata_in = '0;
      for (int l = 0; l < NS; l++) begin
         if (!sd.neg[l]) begin
            if (sovf[l] || squo[l][QW-1] || squo[l][QW-2]) begin
               sat = 1'b1;
               rsp_tdata_in[32*l +: 32] = 32'h7FFF_FFFF;
            end else begin
               rsp_tdata_in[32*l +: 32] = squo[l][31:0];
            end
         end else begin
            if (sovf[l] || squo[l] > QW'(33'h0_8000_0000)) begin
               sat = 1'b1;
               rsp_tdata_in[32*l +: 32] = 32'h8000_0000;
            end else begin
               rsp_tdata_in[32*l +: 32] = 32'(-squo[l][31:0]);
            end
         end
      end
      if (md.big || md.quo[32]) begin
         sat = 1'b1;
         rsp_tdata_in[223:192] = 32'hFFFF_FFFF;
      end else begin
         rsp_tdata_in[223:192] = md.quo[31:0];
      end
      if (md.big) begin
         sat = 1'b1;
         rsp_tdata_in[255:224] = 32'hFFFF_FFFF;
      end else begin
         rsp_tdata_in[255:224] = md.quo[32:1];
      end
      if (sd.degen) begin
         rsp_tdata_in = '0;
         sat = 1'b0;
      end
      rsp_tuser_in = {sat, sd.degen};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= side_ff[tem_pkg::DivLat].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("degenerate result carries nonzero entries");

   a_degen_nosat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tuser[1])
      else $error("degenerate result flagged saturated");

   a_mass_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[255:224] <= rsp_tdata[223:192])
      else $error("mass off-diagonal exceeds diagonal");

endmodule

>>> src/tem_divpipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Uses no package; instantiated by p1_triangle_element_matrices.
module tem_divpipe #(
   parameter int W = 101,
   parameter int Q = 33
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic [Q-1:0] quo,
   output logic         ovf
);

   logic [W-1:0] rem_ff [Q+1];
   logic [W-1:0] den_ff [Q+1];
   logic [Q-1:0] quo_ff [Q+1];
   logic         ovf_ff [Q+1];

   // Quotient would not fit in Q bits: flag and let the bits fall where they may
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num;
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         ovf_ff[0] <= num >= (den << Q);
         for (int i = 0; i < Q; i++) begin
            if (rem_ff[i] >= (den_ff[i] << (Q - 1 - i))) begin
               rem_ff[i+1] <= rem_ff[i] - (den_ff[i] << (Q - 1 - i));
               quo_ff[i+1] <= quo_ff[i] | (Q'(1) << (Q - 1 - i));
            end else begin
               rem_ff[i+1] <= rem_ff[i];
               quo_ff[i+1] <= quo_ff[i];
            end
            den_ff[i+1] <= den_ff[i];
            ovf_ff[i+1] <= ovf_ff[i];
         end
      end
   end

   assign quo = quo_ff[Q];
   assign ovf = ovf_ff[Q];

endmodule
